// ===== src/rcv_pkg.sv =====
// Shared types, constants and register codes for the RGB 3x3 convolution block.
package rcv_pkg;

  // Default line store depth (pixels per row that fit)
  localparam int MAX_WIDTH_DEF = 2048;

  // Frame height limit
  localparam int ROW_LIMIT = 4096;

  // Output queue depth (power of two)
  localparam int FIFO_DEPTH = 16;
  localparam int FIFO_PTR_W = $clog2(FIFO_DEPTH);

  // Configuration register indexes
  localparam logic [2:0] REG_IMAGE_WIDTH  = 3'd0;
  localparam logic [2:0] REG_IMAGE_HEIGHT = 3'd1;
  localparam logic [2:0] REG_KERNEL_LEFT  = 3'd2;
  localparam logic [2:0] REG_KERNEL_MID   = 3'd3;
  localparam logic [2:0] REG_KERNEL_RIGHT = 3'd4;

  // Register reset values
  localparam logic [11:0] WIDTH_RST  = 12'd640;
  localparam logic [12:0] HEIGHT_RST = 13'd480;
  localparam logic [23:0] LEFT_RST   = 24'hFFFFFF;
  localparam logic [23:0] MID_RST    = 24'hFF08FF;
  localparam logic [23:0] RIGHT_RST  = 24'hFFFFFF;

  // Packed pixel: red in the low byte, blue in the high byte
  typedef logic [23:0] rgb_t;

  // Three columns of taps, byte j of entry i is coefficient [i][j]
  typedef logic [2:0][23:0] kernel_t;

  // Line store entry: the two previous rows at one column
  typedef struct packed {
    rgb_t older;
    rgb_t newer;
  } line_pair_t;

  // Input beat
  typedef struct packed {
    logic [7:0] in_red;
    logic [7:0] in_green;
    logic [7:0] in_blue;
  } pixel_in_t;

  // Result beat
  typedef struct packed {
    logic [7:0]  out_red;
    logic [7:0]  out_green;
    logic [7:0]  out_blue;
    logic [10:0] out_column;
    logic [11:0] out_row;
    logic        last_of_run;
  } result_t;

  // Push request into the output queue: up to two results per cycle
  typedef struct packed {
    logic [1:0] cnt;
    result_t    first;
    result_t    second;
  } push_t;

endpackage

// ===== src/rgb_convolution_3x3_top.sv =====
// Streaming 3x3 RGB convolution: raster counters, pipeline control and config registers.
// Pipeline: a beat passes stages p1, p2 and p3 before its results enter the output queue
//   (interior pixels are emitted with the beat one row and one column past them).
// Throughput: one input beat per cycle; a beat that yields two results sends them out one at a
//   time, and in_ready drops while the 16-entry output queue lacks room.
// Reset: config registers take their defaults, raster position and queue clear;
//   line store contents are not cleared.
module rgb_convolution_3x3_top #(
  parameter int MAX_WIDTH = rcv_pkg::MAX_WIDTH_DEF
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_ready,
  input  rcv_pkg::pixel_in_t  in_data,
  output logic                out_valid,
  input  logic                out_ready,
  output rcv_pkg::result_t    out_data,
  input  logic                cfg_valid,
  output logic                cfg_ready,
  input  logic [2:0]          cfg_index,
  input  logic [23:0]         cfg_data
);

  localparam int COL_W  = $clog2(MAX_WIDTH);
  localparam int WV_W   = (($clog2(MAX_WIDTH + 1) > 12) ? $clog2(MAX_WIDTH + 1) : 12) + 1;
  localparam int CNT_W  = rcv_pkg::FIFO_PTR_W + 1;
  localparam int CRD_W  = CNT_W + 1;

  // Config registers
  logic [11:0]      width_r;
  logic [12:0]      height_r;
  rcv_pkg::kernel_t taps_r;

  // Raster position
  logic [COL_W-1:0] col_r, col_nxt;
  logic [11:0]      row_r, row_nxt;

  // Pipeline stage registers
  logic             p1_valid_r, p2_valid_r, p3_valid_r;
  rcv_pkg::rgb_t    p1_pix_r, p2_pix_r, p3_pix_r;
  logic [COL_W-1:0] p1_col_r, p2_col_r, p3_col_r;
  logic [11:0]      p1_row_r, p2_row_r, p3_row_r;
  logic             p1_border_r, p2_border_r, p3_border_r;
  logic             p1_inter_r, p2_inter_r, p3_inter_r;

  logic             in_fire, cfg_fire, dim_write;
  logic [WV_W-1:0]  w_eff, col_p1;
  logic [12:0]      h_eff, row_p1;
  logic             last_col, last_row, border, interior;
  rcv_pkg::rgb_t    in_pix;

  rcv_pkg::line_pair_t ls_rd, ls_wr;
  rcv_pkg::rgb_t       conv_pix;
  rcv_pkg::push_t      push;
  logic [CNT_W-1:0]    fifo_count;
  logic [CRD_W-1:0]    credit;
  logic [31:0]         col_out_cur, col_out_ctr;
  logic [COL_W-1:0]    col_ctr;
  rcv_pkg::result_t    res_conv, res_pass;

  assign cfg_ready = 1'b1;
  assign cfg_fire  = cfg_valid && cfg_ready;
  assign dim_write = cfg_fire && ((cfg_index == rcv_pkg::REG_IMAGE_WIDTH) ||
                                  (cfg_index == rcv_pkg::REG_IMAGE_HEIGHT));
  assign in_fire   = in_valid && in_ready;
  assign in_pix    = {in_data.in_blue, in_data.in_green, in_data.in_red};

  // Config register writes
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      width_r   <= rcv_pkg::WIDTH_RST;
      height_r  <= rcv_pkg::HEIGHT_RST;
      taps_r[0] <= rcv_pkg::LEFT_RST;
      taps_r[1] <= rcv_pkg::MID_RST;
      taps_r[2] <= rcv_pkg::RIGHT_RST;
    end else if (cfg_fire) begin
      case (cfg_index)
        rcv_pkg::REG_IMAGE_WIDTH:  width_r   <= cfg_data[11:0];
        rcv_pkg::REG_IMAGE_HEIGHT: height_r  <= cfg_data[12:0];
        rcv_pkg::REG_KERNEL_LEFT:  taps_r[0] <= cfg_data;
        rcv_pkg::REG_KERNEL_MID:   taps_r[1] <= cfg_data;
        rcv_pkg::REG_KERNEL_RIGHT: taps_r[2] <= cfg_data;
        default: ;
      endcase
    end
  end

  // Clamped frame dimensions
  always_comb begin
    if (width_r == 12'd0) begin
      w_eff = WV_W'(1);
    end else if (WV_W'(width_r) > WV_W'(MAX_WIDTH)) begin
      w_eff = WV_W'(MAX_WIDTH);
    end else begin
      w_eff = WV_W'(width_r);
    end
    if (height_r == 13'd0) begin
      h_eff = 13'd1;
    end else if (height_r > 13'(rcv_pkg::ROW_LIMIT)) begin
      h_eff = 13'(rcv_pkg::ROW_LIMIT);
    end else begin
      h_eff = height_r;
    end
  end

  // Position class of the arriving pixel
  always_comb begin
    col_p1   = WV_W'(col_r) + 1'b1;
    row_p1   = {1'b0, row_r} + 1'b1;
    last_col = (col_p1 >= w_eff);
    last_row = (row_p1 >= h_eff);
    border   = (col_r == '0) || last_col || (row_r == 12'd0) || last_row;
    interior = (col_r >= COL_W'(2)) && (col_p1 <= w_eff) &&
               (row_r >= 12'd2) && (row_p1 <= h_eff);
  end

  // Raster counter advance
  always_comb begin
    col_nxt = col_r;
    row_nxt = row_r;
    if (dim_write) begin
      col_nxt = '0;
      row_nxt = '0;
    end else if (in_fire) begin
      if (last_col) begin
        col_nxt = '0;
        row_nxt = last_row ? 12'd0 : row_p1[11:0];
      end else begin
        col_nxt = col_p1[COL_W-1:0];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      col_r <= '0;
      row_r <= '0;
    end else begin
      col_r <= col_nxt;
      row_r <= row_nxt;
    end
  end

  // Pipeline valids
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      p1_valid_r <= 1'b0;
      p2_valid_r <= 1'b0;
      p3_valid_r <= 1'b0;
    end else begin
      p1_valid_r <= in_fire;
      p2_valid_r <= p1_valid_r;
      p3_valid_r <= p2_valid_r;
    end
  end

  // Pipeline payload
  always_ff @(posedge clk) begin
    p1_pix_r    <= in_pix;
    p1_col_r    <= col_r;
    p1_row_r    <= row_r;
    p1_border_r <= border;
    p1_inter_r  <= interior;
    p2_pix_r    <= p1_pix_r;
    p2_col_r    <= p1_col_r;
    p2_row_r    <= p1_row_r;
    p2_border_r <= p1_border_r;
    p2_inter_r  <= p1_inter_r;
    p3_pix_r    <= p2_pix_r;
    p3_col_r    <= p2_col_r;
    p3_row_r    <= p2_row_r;
    p3_border_r <= p2_border_r;
    p3_inter_r  <= p2_inter_r;
  end

  // Row pair rotates: newer moves to older, the new pixel becomes newer
  assign ls_wr.older = ls_rd.newer;
  assign ls_wr.newer = p1_pix_r;

  rcv_line_store #(
    .DEPTH  (MAX_WIDTH),
    .ADDR_W (COL_W)
  ) u_line_store (
    .clk     (clk),
    .rd_en   (in_fire),
    .rd_addr (col_r),
    .rd_data (ls_rd),
    .wr_en   (p1_valid_r),
    .wr_addr (p1_col_r),
    .wr_data (ls_wr)
  );

  rcv_kernel u_kernel (
    .clk       (clk),
    .shift_en  (p1_valid_r),
    .col_older (ls_rd.older),
    .col_newer (ls_rd.newer),
    .col_pix   (p1_pix_r),
    .taps      (taps_r),
    .conv_pix  (conv_pix)
  );

  // Result assembly: interior result first, border pass-through second
  always_comb begin
    col_ctr     = p3_col_r - 1'b1;
    col_out_ctr = 32'(col_ctr);
    col_out_cur = 32'(p3_col_r);

    res_conv.out_red     = conv_pix[7:0];
    res_conv.out_green   = conv_pix[15:8];
    res_conv.out_blue    = conv_pix[23:16];
    res_conv.out_column  = col_out_ctr[10:0];
    res_conv.out_row     = p3_row_r - 1'b1;
    res_conv.last_of_run = !p3_border_r;

    res_pass.out_red     = p3_pix_r[7:0];
    res_pass.out_green   = p3_pix_r[15:8];
    res_pass.out_blue    = p3_pix_r[23:16];
    res_pass.out_column  = col_out_cur[10:0];
    res_pass.out_row     = p3_row_r;
    res_pass.last_of_run = 1'b1;

    push.first  = res_pass;
    push.second = res_pass;
    push.cnt    = 2'd0;
    if (p3_valid_r) begin
      if (p3_inter_r) begin
        push.first = res_conv;
        push.cnt   = p3_border_r ? 2'd2 : 2'd1;
      end else if (p3_border_r) begin
        push.cnt = 2'd1;
      end
    end
  end

  rcv_out_fifo u_out_fifo (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (push),
    .pop       (out_valid && out_ready),
    .out_valid (out_valid),
    .out_data  (out_data),
    .count     (fifo_count)
  );

  // Accept only while the queue can absorb two results for every beat in flight
  always_comb begin
    credit = CRD_W'(fifo_count) +
             CRD_W'({p1_valid_r, 1'b0}) + CRD_W'({p2_valid_r, 1'b0}) +
             CRD_W'({p3_valid_r, 1'b0});
    in_ready = (credit <= CRD_W'(rcv_pkg::FIFO_DEPTH - 2));
  end

endmodule

// ===== src/rcv_line_store.sv =====
// Two-row line store as one memory of row pairs, with same-address forwarding.
module rcv_line_store #(
  parameter int DEPTH  = rcv_pkg::MAX_WIDTH_DEF,
  parameter int ADDR_W = $clog2(DEPTH)
) (
  input  logic                clk,
  input  logic                rd_en,
  input  logic [ADDR_W-1:0]   rd_addr,
  output rcv_pkg::line_pair_t rd_data,
  input  logic                wr_en,
  input  logic [ADDR_W-1:0]   wr_addr,
  input  rcv_pkg::line_pair_t wr_data
);

  rcv_pkg::line_pair_t mem [DEPTH];
  rcv_pkg::line_pair_t rd_data_r;

  // Write port
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  // Registered read; a write to the same entry in the same cycle is forwarded
  always_ff @(posedge clk) begin
    if (rd_en) begin
      if (wr_en && (wr_addr == rd_addr)) begin
        rd_data_r <= wr_data;
      end else begin
        rd_data_r <= mem[rd_addr];
      end
    end
  end

  assign rd_data = rd_data_r;

endmodule

// ===== src/rcv_kernel.sv =====
// 3x3 window, per-channel products and sums for the convolution path.
module rcv_kernel (
  input  logic             clk,
  input  logic             shift_en,
  input  rcv_pkg::rgb_t    col_older,
  input  rcv_pkg::rgb_t    col_newer,
  input  rcv_pkg::rgb_t    col_pix,
  input  rcv_pkg::kernel_t taps,
  output rcv_pkg::rgb_t    conv_pix
);

  // win_r[k][m]: row k (0 = two rows up), column m (2 = newest)
  logic [2:0][2:0][23:0]        win_r;
  logic [2:0][2:0][2:0][7:0]    prod_nxt;
  logic [2:0][2:0][2:0][7:0]    prod_r;

  // Low byte of an 8x8 product
  function automatic logic [7:0] mul_lo(input logic [7:0] a, input logic [7:0] b);
    logic [15:0] p;
    p = {8'd0, a} * {8'd0, b};
    return p[7:0];
  endfunction

  // Window shifts left by one column per pixel
  always_ff @(posedge clk) begin
    if (shift_en) begin
      for (int k = 0; k < 3; k++) begin
        win_r[k][0] <= win_r[k][1];
        win_r[k][1] <= win_r[k][2];
      end
      win_r[0][2] <= col_older;
      win_r[1][2] <= col_newer;
      win_r[2][2] <= col_pix;
    end
  end

  // Coefficient [i][j] meets the pixel at column offset 2-i, row offset 2-j
  always_comb begin
    for (int ch = 0; ch < 3; ch++) begin
      for (int i = 0; i < 3; i++) begin
        for (int j = 0; j < 3; j++) begin
          prod_nxt[ch][i][j] = mul_lo(taps[i][8*j +: 8], win_r[2-j][2-i][8*ch +: 8]);
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    prod_r <= prod_nxt;
  end

  // Sum of nine bytes, mod 256
  always_comb begin
    for (int ch = 0; ch < 3; ch++) begin
      conv_pix[8*ch +: 8] = ((prod_r[ch][0][0] + prod_r[ch][0][1]) +
                             (prod_r[ch][0][2] + prod_r[ch][1][0])) +
                            ((prod_r[ch][1][1] + prod_r[ch][1][2]) +
                             (prod_r[ch][2][0] + prod_r[ch][2][1])) +
                            prod_r[ch][2][2];
    end
  end

endmodule

// ===== src/rcv_out_fifo.sv =====
// Result queue: up to two pushes and one pop per cycle.
module rcv_out_fifo (
  input  logic                       clk,
  input  logic                       rst_n,
  input  rcv_pkg::push_t             push,
  input  logic                       pop,
  output logic                       out_valid,
  output rcv_pkg::result_t           out_data,
  output logic [rcv_pkg::FIFO_PTR_W:0] count
);

  localparam int PW = rcv_pkg::FIFO_PTR_W;

  rcv_pkg::result_t mem [rcv_pkg::FIFO_DEPTH];
  logic [PW-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [PW-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [PW:0]   count_r, count_nxt;
  logic [PW-1:0] wr_ptr_p1;

  assign wr_ptr_p1 = wr_ptr_r + 1'b1;

  // Storage writes
  always_ff @(posedge clk) begin
    if (push.cnt != 2'd0) begin
      mem[wr_ptr_r] <= push.first;
    end
    if (push.cnt == 2'd2) begin
      mem[wr_ptr_p1] <= push.second;
    end
  end

  // Pointer and fill count update
  always_comb begin
    wr_ptr_nxt = wr_ptr_r + PW'(push.cnt);
    rd_ptr_nxt = pop ? rd_ptr_r + 1'b1 : rd_ptr_r;
    count_nxt  = count_r + (PW+1)'(push.cnt) - (PW+1)'(pop);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  assign out_valid = (count_r != '0);
  assign out_data  = mem[rd_ptr_r];
  assign count     = count_r;

endmodule

// ===== src/rcv_checker.sv =====
// Port-level checks for the RGB 3x3 convolution top, attached by bind.
module rcv_checker (
  input logic             clk,
  input logic             rst_n,
  input logic             in_valid,
  input logic             in_ready,
  input logic             out_valid,
  input logic             out_ready,
  input rcv_pkg::result_t out_data,
  input logic             cfg_valid,
  input logic             cfg_ready
);

  // An offered input beat stays offered until taken
  a_in_hold: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && !in_ready |=> in_valid)
    else $error("input beat withdrawn before acceptance");

  // A stalled result beat holds
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_data))
    else $error("result beat changed while stalled");

  // Queue is empty right after reset
  a_reset_empty: assert property (@(posedge clk)
    !rst_n |=> !out_valid)
    else $error("result valid right after reset");

  // A convolved result with last_of_run low never belongs to the top row
  a_interior_row: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_data.last_of_run |-> out_data.out_row != 12'd0)
    else $error("interior result on top row");

  // Config port never back-pressures
  a_cfg_ready: assert property (@(posedge clk) disable iff (!rst_n)
    cfg_valid |-> cfg_ready)
    else $error("config beat stalled");

endmodule

bind rgb_convolution_3x3_top rcv_checker u_rcv_checker (
  .clk       (clk),
  .rst_n     (rst_n),
  .in_valid  (in_valid),
  .in_ready  (in_ready),
  .out_valid (out_valid),
  .out_ready (out_ready),
  .out_data  (out_data),
  .cfg_valid (cfg_valid),
  .cfg_ready (cfg_ready)
);

// ===== sim/rcv_filter_checker.sv =====
`timescale 1ns / 1ps
// Checker for the 3x3 RGB convolution: tracks config, predicts results and compares output beats.
module rcv_filter_checker #(
  parameter int MAX_WIDTH = rcv_pkg::MAX_WIDTH_DEF
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  input  logic               in_ready,
  input  rcv_pkg::pixel_in_t in_data,
  input  logic               out_valid,
  input  logic               out_ready,
  input  rcv_pkg::result_t   out_data,
  input  logic               cfg_valid,
  input  logic               cfg_ready,
  input  logic [2:0]         cfg_index,
  input  logic [23:0]        cfg_data,
  output int                 outstanding,
  output int                 mismatches
);
  import rcv_pkg::*;

  // Register copies
  logic [11:0] width_reg;
  logic [12:0] height_reg;
  kernel_t     taps;

  // Pixel history: two previous rows and the 3x3 window, [row][col] oldest first
  rgb_t older_line [MAX_WIDTH];
  rgb_t newer_line [MAX_WIDTH];
  rgb_t win [3][3];
  int unsigned col_pos;
  int unsigned row_pos;

  // Results predicted but not yet seen on the output
  result_t pending_results [$];
  result_t want;

  function automatic int unsigned active_width();
    if (width_reg == 0) return 1;
    if (width_reg > MAX_WIDTH) return MAX_WIDTH;
    return width_reg;
  endfunction

  function automatic int unsigned active_height();
    if (height_reg == 0) return 1;
    if (height_reg > ROW_LIMIT) return ROW_LIMIT;
    return height_reg;
  endfunction

  // Kernel applied to the window, each channel mod 256
  function automatic rgb_t filtered_pixel();
    rgb_t       sum;
    logic [7:0] acc;
    logic [7:0] coef;
    logic [7:0] p;
    for (int ch = 0; ch < 3; ch++) begin
      acc = '0;
      for (int i = 0; i < 3; i++) begin
        for (int j = 0; j < 3; j++) begin
          coef = taps[i][8*j +: 8];
          p    = win[2-j][2-i][8*ch +: 8];
          acc  = acc + 8'(coef * p);
        end
      end
      sum[8*ch +: 8] = acc;
    end
    return sum;
  endfunction

  function automatic result_t make_result(rgb_t pix, int unsigned c, int unsigned r,
                                          logic last);
    result_t res;
    res.out_red     = pix[7:0];
    res.out_green   = pix[15:8];
    res.out_blue    = pix[23:16];
    res.out_column  = 11'(c);
    res.out_row     = 12'(r);
    res.last_of_run = last;
    return res;
  endfunction

  task automatic apply_write(input logic [2:0] idx, input logic [23:0] data);
    case (idx)
      REG_IMAGE_WIDTH: begin
        width_reg = data[11:0];
        col_pos   = 0;
        row_pos   = 0;
      end
      REG_IMAGE_HEIGHT: begin
        height_reg = data[12:0];
        col_pos    = 0;
        row_pos    = 0;
      end
      REG_KERNEL_LEFT:  taps[0] = data;
      REG_KERNEL_MID:   taps[1] = data;
      REG_KERNEL_RIGHT: taps[2] = data;
      default: ;
    endcase
  endtask

  // One accepted pixel: update history, queue what it completes, advance raster
  task automatic take_pixel(input pixel_in_t px);
    rgb_t        pix;
    int unsigned w;
    int unsigned h;
    int unsigned c;
    int unsigned r;
    int unsigned idx;
    logic        border;
    logic        interior;
    w   = active_width();
    h   = active_height();
    c   = col_pos;
    r   = row_pos;
    pix = {px.in_blue, px.in_green, px.in_red};
    idx = c % MAX_WIDTH;
    for (int k = 0; k < 3; k++) begin
      win[k][0] = win[k][1];
      win[k][1] = win[k][2];
    end
    win[0][2] = older_line[idx];
    win[1][2] = newer_line[idx];
    win[2][2] = pix;
    older_line[idx] = newer_line[idx];
    newer_line[idx] = pix;
    border   = (c == 0) || (c + 1 >= w) || (r == 0) || (r + 1 >= h);
    interior = (c >= 2) && (c + 1 <= w) && (r >= 2) && (r + 1 <= h);
    // interior result goes out first when one beat completes two
    if (interior) pending_results.push_back(make_result(filtered_pixel(), c - 1, r - 1, !border));
    if (border) pending_results.push_back(make_result(pix, c, r, 1'b1));
    if (c + 1 >= w) begin
      col_pos = 0;
      row_pos = (r + 1 >= h) ? 0 : r + 1;
    end else begin
      col_pos = c + 1;
    end
  endtask

  task automatic compare_field(input string name, input logic [11:0] exp_val,
                               input logic [11:0] got_val);
    if (got_val !== exp_val) begin
      mismatches++;
      $display("%0t: %s mismatch: expected %h, actual %h", $time, name, exp_val, got_val);
    end
  endtask

  // Watch all three channels at the clock edge
  always @(posedge clk) begin
    if (!rst_n) begin
      width_reg  = WIDTH_RST;
      height_reg = HEIGHT_RST;
      taps[0]    = LEFT_RST;
      taps[1]    = MID_RST;
      taps[2]    = RIGHT_RST;
      for (int k = 0; k < MAX_WIDTH; k++) begin
        older_line[k] = '0;
        newer_line[k] = '0;
      end
      for (int k = 0; k < 9; k++) win[k/3][k%3] = '0;
      col_pos    = 0;
      row_pos    = 0;
      mismatches = 0;
      pending_results.delete();
    end else begin
      if (cfg_valid && cfg_ready) apply_write(cfg_index, cfg_data);
      if (in_valid && in_ready) take_pixel(in_data);
      if (out_valid && out_ready) begin
        if (pending_results.size() == 0) begin
          mismatches++;
          $display("%0t: unexpected result beat: expected none, actual %h", $time, out_data);
        end else begin
          want = pending_results.pop_front();
          compare_field("out_red", want.out_red, out_data.out_red);
          compare_field("out_green", want.out_green, out_data.out_green);
          compare_field("out_blue", want.out_blue, out_data.out_blue);
          compare_field("out_column", want.out_column, out_data.out_column);
          compare_field("out_row", want.out_row, out_data.out_row);
          compare_field("last_of_run", want.last_of_run, out_data.last_of_run);
        end
      end
    end
    outstanding <= pending_results.size();
  end

endmodule

// ===== sim/tb_rgb_convolution_3x3_top.sv =====
`timescale 1ns / 1ps
// Testbench top for the 3x3 RGB convolution: clock, reset, stimulus, pacing and verdict.
module tb_rgb_convolution_3x3_top;
  import rcv_pkg::*;

  localparam int ITEM_TARGET = 1950;
  localparam int LATENCY_PAD = 8;
  localparam int QUIET_LIMIT = 4000;
  localparam int PHASE_CAP   = 150;

  logic       clk       = 1'b0;
  logic       rst_n     = 1'b0;
  logic       in_valid  = 1'b0;
  logic       in_ready;
  pixel_in_t  in_data   = '0;
  logic       out_valid;
  logic       out_ready = 1'b0;
  result_t    out_data;
  logic       cfg_valid = 1'b0;
  logic       cfg_ready;
  logic [2:0] cfg_index = '0;
  logic [23:0] cfg_data = '0;

  int outstanding;
  int mismatches;
  int sent          = 0;
  int send_idle_pct = 12;
  int recv_idle_pct = 83;
  int quiet         = 0;
  int unsigned cur_w = WIDTH_RST;
  int unsigned cur_h = HEIGHT_RST;

  rgb_convolution_3x3_top i_dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  rcv_filter_checker i_check (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_valid    (in_valid),
    .in_ready    (in_ready),
    .in_data     (in_data),
    .out_valid   (out_valid),
    .out_ready   (out_ready),
    .out_data    (out_data),
    .cfg_valid   (cfg_valid),
    .cfg_ready   (cfg_ready),
    .cfg_index   (cfg_index),
    .cfg_data    (cfg_data),
    .outstanding (outstanding),
    .mismatches  (mismatches)
  );

  // 10 ns clock
  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Receiver stalls at random
  always @(posedge clk) begin
    out_ready <= rst_n && ($urandom_range(99) >= recv_idle_pct);
  end

  // Watchdog: too long with no beat on any channel
  always @(posedge clk) begin
    if ((in_valid && in_ready) || (out_valid && out_ready) || (cfg_valid && cfg_ready))
      quiet <= 0;
    else
      quiet <= quiet + 1;
    if (quiet >= QUIET_LIMIT) begin
      $display("Verification failed");
      $finish;
    end
  end

  function automatic int unsigned clamp_dim(int unsigned v, int unsigned hi);
    if (v == 0) return 1;
    if (v > hi) return hi;
    return v;
  endfunction

  function automatic pixel_in_t random_pixel();
    case ($urandom_range(7))
      0:       return '0;
      1:       return '1;
      default: return pixel_in_t'($urandom);
    endcase
  endfunction

  function automatic logic [23:0] pick_taps();
    case ($urandom_range(7))
      0:       return 24'h000000;
      1:       return 24'hFFFFFF;
      2:       return 24'h808080;
      3:       return 24'h7F7F7F;
      default: return 24'($urandom);
    endcase
  endfunction

  // One input beat; valid stays up until accepted
  task automatic send_pixel(input pixel_in_t px);
    if (sent < ITEM_TARGET / 3) begin
      send_idle_pct = 12;
      recv_idle_pct = 83;
    end else if (sent < 2 * ITEM_TARGET / 3) begin
      send_idle_pct = 83;
      recv_idle_pct = 12;
    end else begin
      send_idle_pct = 0;
      recv_idle_pct = 0;
    end
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data  <= px;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    sent++;
  endtask

  // Register write; caller drops cfg_valid after the last one
  task automatic write_reg(input logic [2:0] idx, input logic [23:0] val);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    if (idx == REG_IMAGE_WIDTH) cur_w = val[11:0];
    if (idx == REG_IMAGE_HEIGHT) cur_h = val[12:0];
  endtask

  // Hold the input until every predicted result has come out
  task automatic drain();
    in_valid <= 1'b0;
    @(posedge clk);
    wait (outstanding == 0);
    @(posedge clk);
  endtask

  // Drained and past the pipeline depth: safe to touch registers
  task automatic settle();
    drain();
    repeat (LATENCY_PAD) @(posedge clk);
  endtask

  initial begin
    int unsigned kind;
    int unsigned frame;
    int unsigned n;
    int unsigned hold_at;
    logic [11:0] w;
    logic [12:0] h;

    repeat (8) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Default frame, first row: every pixel passes through
    send_pixel(pixel_in_t'(24'h000000));
    send_pixel(pixel_in_t'(24'hFFFFFF));
    send_pixel(pixel_in_t'(24'hAAAAAA));
    send_pixel(pixel_in_t'(24'h555555));
    send_pixel(pixel_in_t'(24'hFF0000));
    send_pixel(pixel_in_t'(24'h00FF00));
    send_pixel(pixel_in_t'(24'h0000FF));
    send_pixel(pixel_in_t'(24'h123456));

    // 3x3 frame with extreme taps: one interior result, two results on the corner
    settle();
    write_reg(REG_IMAGE_WIDTH, 24'd3);
    write_reg(REG_IMAGE_HEIGHT, 24'd3);
    write_reg(REG_KERNEL_LEFT, 24'h7F80FF);
    write_reg(REG_KERNEL_MID, 24'h00FF80);
    write_reg(REG_KERNEL_RIGHT, 24'h7F0001);
    cfg_valid <= 1'b0;
    for (int k = 0; k < 9; k++) begin
      send_pixel((k % 2 == 0) ? pixel_in_t'(24'hFFFFFF) : random_pixel());
    end

    // Frame too small for any interior pixel
    settle();
    write_reg(REG_IMAGE_WIDTH, 24'd2);
    write_reg(REG_IMAGE_HEIGHT, 24'd2);
    cfg_valid <= 1'b0;
    for (int k = 0; k < 4; k++) send_pixel(random_pixel());

    // Random phases: mostly whole small frames, a few extreme sizes
    while (sent < ITEM_TARGET) begin
      settle();
      kind = $urandom_range(9);
      w = 12'($urandom_range(1, 12));
      h = 13'($urandom_range(1, 10));
      if (kind == 0) begin
        case ($urandom_range(3))
          0:       w = 12'd0;
          1:       w = 12'd2048;
          2:       w = 12'd4095;
          default: w = 12'd2047;
        endcase
      end else if (kind == 1) begin
        w = 12'($urandom_range(0, 3));
        case ($urandom_range(3))
          0:       h = 13'd0;
          1:       h = 13'd4096;
          2:       h = 13'd8191;
          default: h = 13'd4095;
        endcase
      end
      if (kind <= 1 || $urandom_range(3) != 0) write_reg(REG_IMAGE_WIDTH, {12'($urandom), w});
      if (kind <= 1 || $urandom_range(3) != 0) write_reg(REG_IMAGE_HEIGHT, {11'($urandom), h});
      for (int i = 0; i < 3; i++) begin
        if ($urandom_range(1) == 1) write_reg(3'(REG_KERNEL_LEFT + i), pick_taps());
      end
      // index past the register map is ignored
      if ($urandom_range(9) == 0) write_reg(3'($urandom_range(7, REG_KERNEL_RIGHT + 1)), 24'($urandom));
      cfg_valid <= 1'b0;

      frame = clamp_dim(cur_w, MAX_WIDTH_DEF) * clamp_dim(cur_h, ROW_LIMIT);
      if (kind <= 1) n = $urandom_range(1, 48);
      else if ($urandom_range(3) == 0) n = $urandom_range(1, frame);
      else n = frame * $urandom_range(1, 2);
      if (n > PHASE_CAP) n = PHASE_CAP;
      hold_at = ($urandom_range(3) == 0) ? $urandom_range(1, n) : 0;

      for (int unsigned i = 1; i <= n; i++) begin
        send_pixel(random_pixel());
        if (i == hold_at) drain();
      end
    end

    drain();
    repeat (2 * LATENCY_PAD) @(posedge clk);
    if (mismatches == 0 && outstanding == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

endmodule

// ===== sim.f =====
src/rcv_pkg.sv
src/rcv_line_store.sv
src/rcv_kernel.sv
src/rcv_out_fifo.sv
src/rgb_convolution_3x3_top.sv
src/rcv_checker.sv
sim/rcv_filter_checker.sv
sim/tb_rgb_convolution_3x3_top.sv
